>>> design/button_click_classifier_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button click classifier
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_UNIT_ASSERT_SVH

// condition must hold at every edge outside reset
`define BCC_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// trigger at one edge implies consequence at the next
`define BCC_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants of the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_DOWN   = 3'd1,
    EV_UP     = 3'd2,
    EV_SINGLE = 3'd3,
    EV_DOUBLE = 3'd4,
    EV_LSTART = 3'd5,
    EV_LHOLD  = 3'd6
  } bcc_event_e;

  typedef enum logic [1:0] {
    CFG_ACTIVE_LEVEL = 2'd0,
    CFG_DEBOUNCE     = 2'd1,
    CFG_SHORT        = 2'd2,
    CFG_LONG         = 2'd3
  } bcc_cfg_idx_e;

  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned TickW      = 16;
  localparam int unsigned RepeatW    = 4;
  localparam int unsigned DebounceW  = 3;

  localparam logic [RepeatW-1:0]   RepeatDouble     = 4'd2;
  localparam logic                 ActiveLevelRst   = 1'b0;
  localparam logic [DebounceW-1:0] DebounceTicksRst = 3'd3;
  localparam logic [TickW-1:0]     ShortTicksRst    = 16'd60;
  localparam logic [TickW-1:0]     LongTicksRst     = 16'd200;

  typedef struct packed {
    logic [2:0]         event_code;
    logic               press_down_fired;
    logic               press_up_fired;
    logic               press_repeat_fired;
    logic               single_click_fired;
    logic               double_click_fired;
    logic               long_start_fired;
    logic               long_hold_fired;
    logic [RepeatW-1:0] press_count;
  } bcc_result_t;

endpackage

>>> design/bcc_if.sv
// ----------------------------------------------------------------------------
// bcc_if
// Valid/ready channels: raw pin samples in, classified results out.
// ----------------------------------------------------------------------------
interface bcc_in_if;
  logic valid;
  logic ready;
  logic pin_sample;

  modport source (output valid, output pin_sample, input ready);
  modport sink   (input valid, input pin_sample, output ready);
endinterface

interface bcc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;
  logic       press_down_fired;
  logic       press_up_fired;
  logic       press_repeat_fired;
  logic       single_click_fired;
  logic       double_click_fired;
  logic       long_start_fired;
  logic       long_hold_fired;
  logic [3:0] press_count;

  modport source (
    output valid, output event_code, output press_down_fired, output press_up_fired,
    output press_repeat_fired, output single_click_fired, output double_click_fired,
    output long_start_fired, output long_hold_fired, output press_count,
    input ready
  );
  modport sink (
    input valid, input event_code, input press_down_fired, input press_up_fired,
    input press_repeat_fired, input single_click_fired, input double_click_fired,
    input long_start_fired, input long_hold_fired, input press_count,
    output ready
  );
endinterface

>>> design/bcc_debounce.sv
// ----------------------------------------------------------------------------
// bcc_debounce
// Accepts a new pin level after enough consecutive differing samples.
// ----------------------------------------------------------------------------
module bcc_debounce (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           pin_i,
  input  logic [bcc_pkg::DebounceW-1:0]  deb_ticks_i,
  output logic                           stable_d_o
);

  logic                          stable_q, stable_d;
  logic [bcc_pkg::DebounceW-1:0] cnt_q, cnt_d, cnt_inc;

  assign cnt_inc = cnt_q + 3'd1;

  always_comb begin
    stable_d = stable_q;
    cnt_d    = '0;
    if (pin_i != stable_q) begin
      cnt_d = cnt_inc;
      if (cnt_inc >= deb_ticks_i) begin
        stable_d = pin_i;
        cnt_d    = '0;
      end
    end
  end

  // stable level resets to the inverse of the reset active level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= ~bcc_pkg::ActiveLevelRst;
      cnt_q    <= '0;
    end else if (en_i) begin
      stable_q <= stable_d;
      cnt_q    <= cnt_d;
    end
  end

  assign stable_d_o = stable_d;

endmodule

>>> design/bcc_fsm.sv
// ----------------------------------------------------------------------------
// bcc_fsm
// Click / double click / long press state machine on the debounced level.
// ----------------------------------------------------------------------------
module bcc_fsm (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       stable_i,
  input  logic                       active_level_i,
  input  logic [bcc_pkg::TickW-1:0]  short_ticks_i,
  input  logic [bcc_pkg::TickW-1:0]  long_ticks_i,
  output bcc_pkg::bcc_result_t       res_o
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_PRESSED = 3'd1,
    ST_WAIT    = 3'd2,
    ST_REPRESS = 3'd3,
    ST_LONG    = 3'd5
  } state_e;

  state_e                        state_q, state_d;
  logic [bcc_pkg::TickW-1:0]     tick_q, tick_d;
  logic [bcc_pkg::RepeatW-1:0]   rep_q, rep_d;
  bcc_pkg::bcc_event_e           ev_q, ev_d;
  logic                          active;
  logic f_down, f_up, f_rep, f_single, f_double, f_lstart, f_lhold;

  assign active = (stable_i == active_level_i);

  always_comb begin
    state_d  = state_q;
    tick_d   = (state_q != ST_IDLE) ? tick_q + 16'd1 : tick_q;
    rep_d    = rep_q;
    ev_d     = ev_q;
    f_down   = 1'b0;
    f_up     = 1'b0;
    f_rep    = 1'b0;
    f_single = 1'b0;
    f_double = 1'b0;
    f_lstart = 1'b0;
    f_lhold  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (active) begin
          ev_d    = bcc_pkg::EV_DOWN;
          f_down  = 1'b1;
          tick_d  = '0;
          rep_d   = 4'd1;
          state_d = ST_PRESSED;
        end else begin
          ev_d = bcc_pkg::EV_NONE;
        end
      end
      ST_PRESSED: begin
        if (!active) begin
          ev_d    = bcc_pkg::EV_UP;
          f_up    = 1'b1;
          tick_d  = '0;
          state_d = ST_WAIT;
        end else if (tick_d > long_ticks_i) begin
          ev_d     = bcc_pkg::EV_LSTART;
          f_lstart = 1'b1;
          state_d  = ST_LONG;
        end
      end
      ST_WAIT: begin
        if (active) begin
          ev_d     = bcc_pkg::EV_DOWN;
          f_down   = 1'b1;
          rep_d    = rep_q + 4'd1;
          f_double = (rep_d == bcc_pkg::RepeatDouble);
          f_rep    = 1'b1;
          tick_d   = '0;
          state_d  = ST_REPRESS;
        end else if (tick_d > short_ticks_i) begin
          // timeout: a double only updates the code, no flag
          if (rep_q == 4'd1) begin
            ev_d     = bcc_pkg::EV_SINGLE;
            f_single = 1'b1;
          end else if (rep_q == bcc_pkg::RepeatDouble) begin
            ev_d = bcc_pkg::EV_DOUBLE;
          end
          state_d = ST_IDLE;
        end
      end
      ST_REPRESS: begin
        if (!active) begin
          ev_d = bcc_pkg::EV_UP;
          f_up = 1'b1;
          if (tick_d < short_ticks_i) begin
            tick_d  = '0;
            state_d = ST_WAIT;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_LONG: begin
        if (active) begin
          ev_d    = bcc_pkg::EV_LHOLD;
          f_lhold = 1'b1;
        end else begin
          ev_d    = bcc_pkg::EV_UP;
          f_up    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tick_q  <= '0;
      rep_q   <= '0;
      ev_q    <= bcc_pkg::EV_NONE;
    end else if (en_i) begin
      state_q <= state_d;
      tick_q  <= tick_d;
      rep_q   <= rep_d;
      ev_q    <= ev_d;
    end
  end

  always_comb begin
    res_o.event_code         = ev_d;
    res_o.press_down_fired   = f_down;
    res_o.press_up_fired     = f_up;
    res_o.press_repeat_fired = f_rep;
    res_o.single_click_fired = f_single;
    res_o.double_click_fired = f_double;
    res_o.long_start_fired   = f_lstart;
    res_o.long_hold_fired    = f_lhold;
    res_o.press_count        = rep_d;
  end

endmodule

>>> design/button_click_classifier_unit.sv
// Result path: an input transfer fills the input register; the debounce and click
//   state then update together into the result register once it is free or drained.
// Throughput: one tick per cycle unless the result register is stalled.
// Reset: asynchronous, active low; state machine idle, counters zero, stable level
//   inactive, configuration back to its defaults, both channel registers empty.
// ----------------------------------------------------------------------------
// button_click_classifier_unit
// Debounced button classifier: press, release, single, double and long press.
// ----------------------------------------------------------------------------
`include "button_click_classifier_unit_assert.svh"

module button_click_classifier_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bcc_in_if.sink                          in_if,
  bcc_out_if.source                       out_if,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [bcc_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  logic                           active_level_q;
  logic [bcc_pkg::DebounceW-1:0]  deb_ticks_q;
  logic [bcc_pkg::TickW-1:0]      short_ticks_q;
  logic [bcc_pkg::TickW-1:0]      long_ticks_q;

  logic                  in_vld_q, pin_q;
  logic                  out_vld_q;
  bcc_pkg::bcc_result_t  res_q, res_d;
  logic                  adv, in_xfer, stable_d;
  logic                  flags_ok, double_ok, down_ok;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_level_q <= bcc_pkg::ActiveLevelRst;
      deb_ticks_q    <= bcc_pkg::DebounceTicksRst;
      short_ticks_q  <= bcc_pkg::ShortTicksRst;
      long_ticks_q   <= bcc_pkg::LongTicksRst;
    end else if (cfg_we_i) begin
      case (bcc_pkg::bcc_cfg_idx_e'(cfg_idx_i))
        bcc_pkg::CFG_ACTIVE_LEVEL: active_level_q <= cfg_wdata_i[0];
        bcc_pkg::CFG_DEBOUNCE:     deb_ticks_q    <= cfg_wdata_i[bcc_pkg::DebounceW-1:0];
        bcc_pkg::CFG_SHORT:        short_ticks_q  <= cfg_wdata_i;
        bcc_pkg::CFG_LONG:         long_ticks_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage advances when the result register is free or being drained
  assign adv          = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready  = !in_vld_q || adv;
  assign in_xfer      = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pin_q <= in_if.pin_sample;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  bcc_debounce u_debounce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .pin_i       (pin_q),
    .deb_ticks_i (deb_ticks_q),
    .stable_d_o  (stable_d)
  );

  bcc_fsm u_fsm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (adv),
    .stable_i       (stable_d),
    .active_level_i (active_level_q),
    .short_ticks_i  (short_ticks_q),
    .long_ticks_i   (long_ticks_q),
    .res_o          (res_d)
  );

  assign out_if.valid              = out_vld_q;
  assign out_if.event_code         = res_q.event_code;
  assign out_if.press_down_fired   = res_q.press_down_fired;
  assign out_if.press_up_fired     = res_q.press_up_fired;
  assign out_if.press_repeat_fired = res_q.press_repeat_fired;
  assign out_if.single_click_fired = res_q.single_click_fired;
  assign out_if.double_click_fired = res_q.double_click_fired;
  assign out_if.long_start_fired   = res_q.long_start_fired;
  assign out_if.long_hold_fired    = res_q.long_hold_fired;
  assign out_if.press_count        = res_q.press_count;

  assign flags_ok  = $onehot0({res_q.press_down_fired, res_q.press_up_fired,
                               res_q.single_click_fired, res_q.long_start_fired,
                               res_q.long_hold_fired});
  assign double_ok = !res_q.double_click_fired ||
                     (res_q.press_down_fired && res_q.press_repeat_fired &&
                      res_q.press_count == bcc_pkg::RepeatDouble);
  assign down_ok   = !res_q.press_down_fired || res_q.event_code == bcc_pkg::EV_DOWN;

  `BCC_ASSERT(a_flags_exclusive, !out_vld_q || flags_ok, "conflicting event flags")
  `BCC_ASSERT(a_double_on_press, !out_vld_q || double_ok, "double click without second press")
  `BCC_ASSERT(a_down_code, !out_vld_q || down_ok, "press down flag with wrong event code")
  `BCC_ASSERT_NEXT(a_stage_holds, in_vld_q && out_vld_q && !out_if.ready, in_vld_q, "pending tick dropped while result stalled")

endmodule
